### rtl/core/hrj_pkg.sv
// Shared types, constants and helpers for the homography residual and Jacobian block.
// Used by every module under rtl/core; depends on nothing else.
package hrj_pkg;

    localparam int COORD_W         = 32;
    localparam int PARAM_W         = 48;
    localparam int VALUE_W         = 64;
    localparam int WIDE_W          = 130;
    localparam int PARTIAL_W       = 32;
    localparam int CFG_IDX_W       = 4;
    localparam int DIV_STEPS       = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] IDX_AFFINE_XX = 4'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_AFFINE_XY = 4'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_SHIFT_X   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_AFFINE_YX = 4'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_AFFINE_YY = 4'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_SHIFT_Y   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_PERSP_X   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_PERSP_Y   = 4'd7;

    localparam logic signed [PARAM_W-1:0] PARAM_ONE = 48'sh0001_0000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 64'sh8000_0000_0000_0000;
    // 1.0 at the scale of a Q16.32 by Q16.16 product
    localparam logic signed [WIDE_W-1:0]  ONE_Q48   = 130'sh1_0000_0000_0000;

    typedef struct packed {
        logic signed [PARAM_W-1:0] affine_xx;
        logic signed [PARAM_W-1:0] affine_xy;
        logic signed [PARAM_W-1:0] shift_x;
        logic signed [PARAM_W-1:0] affine_yx;
        logic signed [PARAM_W-1:0] affine_yy;
        logic signed [PARAM_W-1:0] shift_y;
        logic signed [PARAM_W-1:0] persp_x;
        logic signed [PARAM_W-1:0] persp_y;
    } hom_t;

    localparam hom_t HOM_RESET = '{
        affine_xx: PARAM_ONE, affine_xy: '0, shift_x: '0,
        affine_yx: '0, affine_yy: PARAM_ONE, shift_y: '0,
        persp_x: '0, persp_y: '0
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
    } point_t;

    typedef struct packed {
        point_t                    pt;
        logic signed [VALUE_W-1:0] den;
        logic signed [VALUE_W-1:0] nx;
        logic signed [VALUE_W-1:0] ny;
        logic                      degen;
    } qitem_t;

    // Clamp a wide signed value to the signed 64-bit range.
    function automatic logic signed [VALUE_W-1:0] sat64(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-VALUE_W:0] top_bits;
        top_bits = v[WIDE_W-1:VALUE_W-1];
        if (top_bits == '0 || top_bits == '1)
            return v[VALUE_W-1:0];
        else if (v[WIDE_W-1])
            return VALUE_MIN;
        else
            return VALUE_MAX;
    endfunction

endpackage

### rtl/core/hrj_mul.sv
// Two-stage signed multiplier built from four partial products of about 32 by 32 bits.
// Depends on hrj_pkg for the partial product width.
module hrj_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    import hrj_pkg::*;

    localparam int LW  = PARTIAL_W;
    localparam int AHW = AW - LW;
    localparam int BHW = BW - LW;
    localparam int PW  = AW + BW;

    logic        [2*LW-1:0]    ll_reg;
    logic signed [LW+BHW:0]    lh_reg;
    logic signed [AHW+LW:0]    hl_reg;
    logic signed [AHW+BHW-1:0] hh_reg;
    logic signed [PW-1:0]      p_reg;

    // Stage one forms the partial products, stage two adds them at their weights.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[LW-1:0] * b[LW-1:0];
            lh_reg <= $signed({1'b0, a[LW-1:0]}) * $signed(b[BW-1:LW]);
            hl_reg <= $signed(a[AW-1:LW]) * $signed({1'b0, b[LW-1:0]});
            hh_reg <= $signed(a[AW-1:LW]) * $signed(b[BW-1:LW]);
            p_reg  <= (PW'(hh_reg) <<< (2 * LW)) + (PW'(lh_reg) <<< LW)
                    + (PW'(hl_reg) <<< LW) + PW'(ll_reg);
        end
    end

    assign p = p_reg;

endmodule

### rtl/core/hrj_front.sv
// Front end: takes point requests, forms the projective denominator and both numerators,
// flags a zero denominator and hands the result to the queue. Depends on hrj_pkg, hrj_mul.
module hrj_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hrj_pkg::hom_t                    hom,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [hrj_pkg::COORD_W-1:0] src_x,
    input  logic signed [hrj_pkg::COORD_W-1:0] src_y,
    input  logic signed [hrj_pkg::COORD_W-1:0] dst_x,
    input  logic signed [hrj_pkg::COORD_W-1:0] dst_y,
    input  logic                             q_full,
    output logic                             push,
    output hrj_pkg::qitem_t                  push_item
);
    import hrj_pkg::*;

    localparam int XW     = COORD_W + 1;
    localparam int PROD_W = PARAM_W + XW;

    logic                     en;
    logic                     f1_v_reg, f2_v_reg, f3_v_reg;
    point_t                   pt1_reg, pt2_reg;
    qitem_t                   item_reg, item_next;
    logic signed [XW-1:0]     x_ext, y_ext;
    logic signed [PROD_W-1:0] pr_px, pr_py, pr_xx, pr_xy, pr_yx, pr_yy;
    logic signed [WIDE_W-1:0] s_den, s_nx, s_ny;

    // The whole front advances together; it holds only when its result cannot enter the queue.
    assign en       = !(f3_v_reg && q_full);
    assign in_stall = !en;
    assign push     = f3_v_reg && !q_full;
    assign push_item = item_reg;

    assign x_ext = {src_x[COORD_W-1], src_x};
    assign y_ext = {src_y[COORD_W-1], src_y};

    hrj_mul #(.AW(PARAM_W), .BW(XW)) u_mul_px (.clk, .en, .a(hom.persp_x),   .b(x_ext), .p(pr_px));
    hrj_mul #(.AW(PARAM_W), .BW(XW)) u_mul_py (.clk, .en, .a(hom.persp_y),   .b(y_ext), .p(pr_py));
    hrj_mul #(.AW(PARAM_W), .BW(XW)) u_mul_xx (.clk, .en, .a(hom.affine_xx), .b(x_ext), .p(pr_xx));
    hrj_mul #(.AW(PARAM_W), .BW(XW)) u_mul_xy (.clk, .en, .a(hom.affine_xy), .b(y_ext), .p(pr_xy));
    hrj_mul #(.AW(PARAM_W), .BW(XW)) u_mul_yx (.clk, .en, .a(hom.affine_yx), .b(x_ext), .p(pr_yx));
    hrj_mul #(.AW(PARAM_W), .BW(XW)) u_mul_yy (.clk, .en, .a(hom.affine_yy), .b(y_ext), .p(pr_yy));

    always_comb
    begin
        s_den = WIDE_W'(pr_px) + WIDE_W'(pr_py) + ONE_Q48;
        s_nx  = WIDE_W'(pr_xx) + WIDE_W'(pr_xy) + (WIDE_W'(hom.shift_x) <<< 16);
        s_ny  = WIDE_W'(pr_yx) + WIDE_W'(pr_yy) + (WIDE_W'(hom.shift_y) <<< 16);
        item_next.pt    = pt2_reg;
        item_next.den   = sat64(s_den >>> 16);
        item_next.nx    = sat64(s_nx >>> 16);
        item_next.ny    = sat64(s_ny >>> 16);
        item_next.degen = (item_next.den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= in_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt1_reg  <= '{x: src_x, y: src_y, dx: dst_x, dy: dst_y};
            pt2_reg  <= pt1_reg;
            item_reg <= item_next;
        end
    end

endmodule

### rtl/core/hrj_queue.sv
// Short queue that decouples the front end from the divider and row pipeline.
// Depends on hrj_pkg for the entry type.
module hrj_queue #(
    parameter int DEPTH = hrj_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hrj_pkg::qitem_t push_item,
    output logic            full,
    input  logic            pop,
    output hrj_pkg::qitem_t head,
    output logic            empty
);
    import hrj_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qitem_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/core/hrj_back.sv
// Back end: pipelined reciprocal divider, projection and Jacobian multipliers, and the
// row output register that shows the two rows in turn. Depends on hrj_pkg and hrj_mul.
module hrj_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hrj_pkg::qitem_t                    head,
    input  logic                               q_empty,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [hrj_pkg::VALUE_W-1:0] residual,
    output logic signed [hrj_pkg::VALUE_W-1:0] grad_affine_xx,
    output logic signed [hrj_pkg::VALUE_W-1:0] grad_affine_xy,
    output logic signed [hrj_pkg::VALUE_W-1:0] grad_shift_x,
    output logic signed [hrj_pkg::VALUE_W-1:0] grad_affine_yx,
    output logic signed [hrj_pkg::VALUE_W-1:0] grad_affine_yy,
    output logic signed [hrj_pkg::VALUE_W-1:0] grad_shift_y,
    output logic signed [hrj_pkg::VALUE_W-1:0] grad_persp_x,
    output logic signed [hrj_pkg::VALUE_W-1:0] grad_persp_y,
    output logic                               degenerate,
    output logic                               last
);
    import hrj_pkg::*;

    localparam int XW = COORD_W + 1;

    typedef struct packed {
        point_t                    pt;
        logic signed [VALUE_W-1:0] nx;
        logic signed [VALUE_W-1:0] ny;
        logic                      neg;
        logic                      unit;
        logic                      degen;
        logic [VALUE_W-1:0]        dmag;
        logic [VALUE_W-1:0]        rem;
        logic [VALUE_W-1:0]        quo;
    } div_t;

    typedef struct packed {
        point_t                    pt;
        logic signed [VALUE_W-1:0] nx;
        logic signed [VALUE_W-1:0] ny;
        logic signed [VALUE_W-1:0] w;
        logic                      degen;
    } ws_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] px;
        logic signed [VALUE_W-1:0] py;
        logic signed [VALUE_W-1:0] gx;
        logic signed [VALUE_W-1:0] gy;
        logic signed [VALUE_W-1:0] w;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic                      degen;
    } ps_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] res_x;
        logic signed [VALUE_W-1:0] res_y;
        logic signed [VALUE_W-1:0] gx;
        logic signed [VALUE_W-1:0] gy;
        logic signed [VALUE_W-1:0] w;
        logic signed [VALUE_W-1:0] pers_xx;
        logic signed [VALUE_W-1:0] pers_yx;
        logic signed [VALUE_W-1:0] pers_xy;
        logic signed [VALUE_W-1:0] pers_yy;
        logic                      degen;
    } fs_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] residual;
        logic signed [VALUE_W-1:0] gaxx;
        logic signed [VALUE_W-1:0] gaxy;
        logic signed [VALUE_W-1:0] gsx;
        logic signed [VALUE_W-1:0] gayx;
        logic signed [VALUE_W-1:0] gayy;
        logic signed [VALUE_W-1:0] gsy;
        logic signed [VALUE_W-1:0] gpx;
        logic signed [VALUE_W-1:0] gpy;
        logic                      degen;
        logic                      last;
    } row_t;

    // One restoring division step: double the remainder, subtract the divisor if it fits.
    function automatic div_t div_step(input div_t s);
        div_t               r;
        logic [VALUE_W-1:0] r2;
        r  = s;
        r2 = {s.rem[VALUE_W-2:0], 1'b0};
        if (r2 >= s.dmag)
        begin
            r.rem = r2 - s.dmag;
            r.quo = {s.quo[VALUE_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = r2;
            r.quo = {s.quo[VALUE_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic en;
    logic out_load;

    logic div_v_reg [DIV_STEPS+1];
    div_t div_reg   [DIV_STEPS+1];
    div_t div_init;

    logic ws_v_reg, m1a_v_reg, m1b_v_reg, ps_v_reg, m2a_v_reg, m2b_v_reg, fin_v_reg;
    logic fin_row_reg;
    logic out_valid_reg;
    ws_t  ws_reg, ws_next, m1a_reg, m1b_reg;
    ps_t  ps_reg, ps_next, m2a_reg, m2b_reg;
    fs_t  fin_reg, fin_next;
    row_t row_reg, row_next;

    logic signed [2*VALUE_W-1:0]  pr_nxw, pr_nyw, pr_pxx, pr_pyx, pr_pxy, pr_pyy;
    logic signed [XW+VALUE_W-1:0] pr_xw, pr_yw;
    logic signed [XW-1:0]         x_ext, y_ext;

    assign out_load = !out_valid_reg || !out_stall;
    // The last stage holds a point for two rows; the pipeline moves when it is empty
    // or its second row is being taken.
    assign en  = !fin_v_reg || (fin_row_reg && out_load);
    assign pop = en && !q_empty;

    always_comb
    begin
        div_init.pt    = head.pt;
        div_init.nx    = head.nx;
        div_init.ny    = head.ny;
        div_init.neg   = head.den[VALUE_W-1];
        div_init.degen = head.degen;
        div_init.dmag  = head.den[VALUE_W-1] ? (~head.den + 1'b1) : head.den;
        div_init.unit  = (div_init.dmag == VALUE_W'(1));
        div_init.rem   = VALUE_W'(1);
        div_init.quo   = '0;
    end

    always_comb
    begin
        ws_next.pt    = div_reg[DIV_STEPS].pt;
        ws_next.nx    = div_reg[DIV_STEPS].nx;
        ws_next.ny    = div_reg[DIV_STEPS].ny;
        ws_next.degen = div_reg[DIV_STEPS].degen;
        if (div_reg[DIV_STEPS].degen)
            ws_next.w = '0;
        else if (div_reg[DIV_STEPS].unit)
            ws_next.w = div_reg[DIV_STEPS].neg ? VALUE_MIN : VALUE_MAX;
        else if (div_reg[DIV_STEPS].neg)
            ws_next.w = -$signed(div_reg[DIV_STEPS].quo);
        else if (div_reg[DIV_STEPS].quo[VALUE_W-1])
            ws_next.w = VALUE_MAX;
        else
            ws_next.w = $signed(div_reg[DIV_STEPS].quo);
    end

    assign x_ext = {ws_reg.pt.x[COORD_W-1], ws_reg.pt.x};
    assign y_ext = {ws_reg.pt.y[COORD_W-1], ws_reg.pt.y};

    hrj_mul #(.AW(VALUE_W), .BW(VALUE_W)) u_mul_nxw (.clk, .en, .a(ws_reg.nx), .b(ws_reg.w), .p(pr_nxw));
    hrj_mul #(.AW(VALUE_W), .BW(VALUE_W)) u_mul_nyw (.clk, .en, .a(ws_reg.ny), .b(ws_reg.w), .p(pr_nyw));
    hrj_mul #(.AW(XW), .BW(VALUE_W))      u_mul_xw  (.clk, .en, .a(x_ext), .b(ws_reg.w), .p(pr_xw));
    hrj_mul #(.AW(XW), .BW(VALUE_W))      u_mul_yw  (.clk, .en, .a(y_ext), .b(ws_reg.w), .p(pr_yw));

    always_comb
    begin
        ps_next.px    = sat64(WIDE_W'(pr_nxw) >>> 32);
        ps_next.py    = sat64(WIDE_W'(pr_nyw) >>> 32);
        ps_next.gx    = sat64(WIDE_W'(pr_xw) >>> 16);
        ps_next.gy    = sat64(WIDE_W'(pr_yw) >>> 16);
        ps_next.w     = m1b_reg.w;
        ps_next.dx    = m1b_reg.pt.dx;
        ps_next.dy    = m1b_reg.pt.dy;
        ps_next.degen = m1b_reg.degen;
    end

    hrj_mul #(.AW(VALUE_W), .BW(VALUE_W)) u_mul_pxx (.clk, .en, .a(ps_reg.gx), .b(ps_reg.px), .p(pr_pxx));
    hrj_mul #(.AW(VALUE_W), .BW(VALUE_W)) u_mul_pyx (.clk, .en, .a(ps_reg.gy), .b(ps_reg.px), .p(pr_pyx));
    hrj_mul #(.AW(VALUE_W), .BW(VALUE_W)) u_mul_pxy (.clk, .en, .a(ps_reg.gx), .b(ps_reg.py), .p(pr_pxy));
    hrj_mul #(.AW(VALUE_W), .BW(VALUE_W)) u_mul_pyy (.clk, .en, .a(ps_reg.gy), .b(ps_reg.py), .p(pr_pyy));

    always_comb
    begin
        fin_next.res_x   = sat64(WIDE_W'(m2b_reg.px) - (WIDE_W'(m2b_reg.dx) <<< 16));
        fin_next.res_y   = sat64(WIDE_W'(m2b_reg.py) - (WIDE_W'(m2b_reg.dy) <<< 16));
        fin_next.gx      = m2b_reg.gx;
        fin_next.gy      = m2b_reg.gy;
        fin_next.w       = m2b_reg.w;
        fin_next.pers_xx = sat64(-(WIDE_W'(pr_pxx) >>> 32));
        fin_next.pers_yx = sat64(-(WIDE_W'(pr_pyx) >>> 32));
        fin_next.pers_xy = sat64(-(WIDE_W'(pr_pxy) >>> 32));
        fin_next.pers_yy = sat64(-(WIDE_W'(pr_pyy) >>> 32));
        fin_next.degen   = m2b_reg.degen;
    end

    always_comb
    begin
        row_next       = '0;
        row_next.degen = fin_reg.degen;
        if (!fin_row_reg)
        begin
            row_next.residual = fin_reg.res_x;
            row_next.gaxx     = fin_reg.gx;
            row_next.gaxy     = fin_reg.gy;
            row_next.gsx      = fin_reg.w;
            row_next.gpx      = fin_reg.pers_xx;
            row_next.gpy      = fin_reg.pers_yx;
            row_next.last     = 1'b0;
        end
        else
        begin
            row_next.residual = fin_reg.res_y;
            row_next.gayx     = fin_reg.gx;
            row_next.gayy     = fin_reg.gy;
            row_next.gsy      = fin_reg.w;
            row_next.gpx      = fin_reg.pers_xy;
            row_next.gpy      = fin_reg.pers_yy;
            row_next.last     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                div_v_reg[k] <= 1'b0;
            ws_v_reg      <= 1'b0;
            m1a_v_reg     <= 1'b0;
            m1b_v_reg     <= 1'b0;
            ps_v_reg      <= 1'b0;
            m2a_v_reg     <= 1'b0;
            m2b_v_reg     <= 1'b0;
            fin_v_reg     <= 1'b0;
            fin_row_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                div_v_reg[0] <= !q_empty;
                for (int k = 1; k <= DIV_STEPS; k++)
                    div_v_reg[k] <= div_v_reg[k-1];
                ws_v_reg  <= div_v_reg[DIV_STEPS];
                m1a_v_reg <= ws_v_reg;
                m1b_v_reg <= m1a_v_reg;
                ps_v_reg  <= m1b_v_reg;
                m2a_v_reg <= ps_v_reg;
                m2b_v_reg <= m2a_v_reg;
                fin_v_reg <= m2b_v_reg;
            end
            if (fin_v_reg && out_load)
                fin_row_reg <= !fin_row_reg;
            if (out_load)
                out_valid_reg <= fin_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= div_init;
            for (int k = 1; k <= DIV_STEPS; k++)
                div_reg[k] <= div_step(div_reg[k-1]);
            ws_reg  <= ws_next;
            m1a_reg <= ws_reg;
            m1b_reg <= m1a_reg;
            ps_reg  <= ps_next;
            m2a_reg <= ps_reg;
            m2b_reg <= m2a_reg;
            fin_reg <= fin_next;
        end
        if (out_load && fin_v_reg)
            row_reg <= row_next;
    end

    assign out_valid      = out_valid_reg;
    assign residual       = row_reg.residual;
    assign grad_affine_xx = row_reg.gaxx;
    assign grad_affine_xy = row_reg.gaxy;
    assign grad_shift_x   = row_reg.gsx;
    assign grad_affine_yx = row_reg.gayx;
    assign grad_affine_yy = row_reg.gayy;
    assign grad_shift_y   = row_reg.gsy;
    assign grad_persp_x   = row_reg.gpx;
    assign grad_persp_y   = row_reg.gpy;
    assign degenerate     = row_reg.degen;
    assign last           = row_reg.last;

endmodule

### rtl/core/homography_residual_jacobian.sv
// Homography reprojection residual and Jacobian, one point request in, two row requests out.
// A point passes the front end, queue, divider and multipliers to a last stage that shows
// its x row, then its y row; new points enter before earlier ones are out.
// Reset: asynchronous, active low; clears all valid state and loads the identity homography.
// Depends on hrj_pkg, hrj_mul, hrj_front, hrj_queue and hrj_back.
module homography_residual_jacobian #(
    parameter int QUEUE_DEPTH = hrj_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [hrj_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hrj_pkg::PARAM_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [hrj_pkg::COORD_W-1:0]   src_x,
    input  logic signed [hrj_pkg::COORD_W-1:0]   src_y,
    input  logic signed [hrj_pkg::COORD_W-1:0]   dst_x,
    input  logic signed [hrj_pkg::COORD_W-1:0]   dst_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [hrj_pkg::VALUE_W-1:0]   residual,
    output logic signed [hrj_pkg::VALUE_W-1:0]   grad_affine_xx,
    output logic signed [hrj_pkg::VALUE_W-1:0]   grad_affine_xy,
    output logic signed [hrj_pkg::VALUE_W-1:0]   grad_shift_x,
    output logic signed [hrj_pkg::VALUE_W-1:0]   grad_affine_yx,
    output logic signed [hrj_pkg::VALUE_W-1:0]   grad_affine_yy,
    output logic signed [hrj_pkg::VALUE_W-1:0]   grad_shift_y,
    output logic signed [hrj_pkg::VALUE_W-1:0]   grad_persp_x,
    output logic signed [hrj_pkg::VALUE_W-1:0]   grad_persp_y,
    output logic                                 degenerate,
    output logic                                 last
);
    import hrj_pkg::*;

    // Eight homography coefficients, to be changed by the user only while the block is idle;
    // not enforced here. The front end reads them directly, with no copy kept per point.
    hom_t   hom_reg;

    logic   q_full, q_empty, push, pop;
    qitem_t push_item, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hom_reg <= HOM_RESET;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                IDX_AFFINE_XX: hom_reg.affine_xx <= cfg_data;
                IDX_AFFINE_XY: hom_reg.affine_xy <= cfg_data;
                IDX_SHIFT_X:   hom_reg.shift_x   <= cfg_data;
                IDX_AFFINE_YX: hom_reg.affine_yx <= cfg_data;
                IDX_AFFINE_YY: hom_reg.affine_yy <= cfg_data;
                IDX_SHIFT_Y:   hom_reg.shift_y   <= cfg_data;
                IDX_PERSP_X:   hom_reg.persp_x   <= cfg_data;
                IDX_PERSP_Y:   hom_reg.persp_y   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The front end takes a point each cycle while the queue has room. It projects the
    // numerators and the denominator in three stages and marks a zero denominator.
    hrj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hom       (hom_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .src_x     (src_x),
        .src_y     (src_y),
        .dst_x     (dst_x),
        .dst_y     (dst_y),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // The queue lets the front keep accepting points while the back end waits on the
    // output side.
    hrj_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    // The back end runs a 64-stage reciprocal divider, then two rounds of multiplies for
    // the projected point and the perspective terms, and emits the x row and the y row
    // from its last stage through a registered output.
    hrj_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_empty        (q_empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .residual       (residual),
        .grad_affine_xx (grad_affine_xx),
        .grad_affine_xy (grad_affine_xy),
        .grad_shift_x   (grad_shift_x),
        .grad_affine_yx (grad_affine_yx),
        .grad_affine_yy (grad_affine_yy),
        .grad_shift_y   (grad_shift_y),
        .grad_persp_x   (grad_persp_x),
        .grad_persp_y   (grad_persp_y),
        .degenerate     (degenerate),
        .last           (last)
    );

endmodule
